FILE: rtl/pcv_pkg.sv
// Package: types, constants and codes shared by the point cloud voxelizer.
`timescale 1ns / 1ps
package pcv_pkg;

	localparam int GRID_X = 256;
	localparam int GRID_Y = 256;
	localparam int GRID_Z = 16;
	localparam int VOXEL_CAPACITY = 16384;
	localparam int SLOT_CAPACITY = 32;

	localparam int CX_W = $clog2(GRID_X);
	localparam int CY_W = $clog2(GRID_Y);
	localparam int CZ_W = $clog2(GRID_Z);
	localparam int CELL_W = CX_W + CY_W + CZ_W;
	localparam int VOX_W = $clog2(VOXEL_CAPACITY);
	localparam int CNT_W = VOX_W + 1;
	localparam int SLOT_W = $clog2(SLOT_CAPACITY);
	localparam int FILL_W = SLOT_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_INV_X    = 3'd3,
		REG_INV_Y    = 3'd4,
		REG_INV_Z    = 3'd5,
		REG_PLIM     = 3'd6,
		REG_VLIM     = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_STORED     = 2'd0,
		ST_OUT_GRID   = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_VOXEL_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_LOOK,
		S_FILL,
		S_DONE,
		S_CLEAR,
		S_INIT
	} state_t;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic               frame_end;
	} point_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] voxel_index;
		logic [4:0]  point_slot;
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic [3:0]  cell_z;
		logic        new_voxel;
		logic [14:0] voxel_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture point, start products
		logic look;      // issue cell map read
		logic fill;      // issue fill read / allocate
		logic finish;    // update fill, present result
		logic clr_start; // begin clear walk
		logic clr_step;  // one clear step
		logic init_step; // one init step
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic init_done;
	} dp_sts_t;

endpackage

FILE: rtl/pcv_ctrl.sv
// Controller: sequences the per-point steps, the frame-end clear walk and the initial clear.
`timescale 1ns / 1ps
module pcv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             frame_end,
	input  pcv_pkg::dp_sts_t sts,
	output logic             busy,
	output pcv_pkg::dp_cmd_t cmd
);

	pcv_pkg::state_t state_q, state_nx;
	logic fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcv_pkg::S_INIT;
			fe_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == pcv_pkg::S_IDLE && start)
				fe_q <= frame_end;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pcv_pkg::S_INIT:  if (sts.init_done) state_nx = pcv_pkg::S_IDLE;
			pcv_pkg::S_IDLE:  if (start) state_nx = pcv_pkg::S_CALC;
			pcv_pkg::S_CALC:  state_nx = pcv_pkg::S_LOOK;
			pcv_pkg::S_LOOK:  state_nx = pcv_pkg::S_FILL;
			pcv_pkg::S_FILL:  state_nx = pcv_pkg::S_DONE;
			pcv_pkg::S_DONE:  state_nx = fe_q ? pcv_pkg::S_CLEAR : pcv_pkg::S_IDLE;
			pcv_pkg::S_CLEAR: if (sts.clr_done) state_nx = pcv_pkg::S_IDLE;
			default:          state_nx = pcv_pkg::S_IDLE;
		endcase
	end

	// S_LOOK waits for the cell map read
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			pcv_pkg::S_INIT:  cmd.init_step = 1'b1;
			pcv_pkg::S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			pcv_pkg::S_CALC:  cmd.look = 1'b1;
			pcv_pkg::S_LOOK:  ;
			pcv_pkg::S_FILL:  cmd.fill = 1'b1;
			pcv_pkg::S_DONE: begin
				cmd.finish = 1'b1;
				cmd.clr_start = fe_q;
			end
			pcv_pkg::S_CLEAR: cmd.clr_step = 1'b1;
			default:          cmd = '0;
		endcase
	end

	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcv_pkg::S_IDLE) |-> !busy)
		else $error("busy high in idle");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.look, cmd.fill, cmd.finish, cmd.clr_step, cmd.init_step}))
		else $error("more than one command");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.look |-> ##2 cmd.fill)
		else $error("lookup not followed by fill step");

endmodule

FILE: rtl/pcv_datapath.sv
// Datapath: cell computation, cell map, voxel list, fill counters and result register.
`timescale 1ns / 1ps
module pcv_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcv_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [pcv_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  pcv_pkg::point_t                     point,
	input  pcv_pkg::dp_cmd_t                    cmd,
	output pcv_pkg::dp_sts_t                    sts,
	output logic                                done,
	output pcv_pkg::result_t                    result
);

	localparam int NCELL = 1 << pcv_pkg::CELL_W;

	logic signed [23:0] org_x_q, org_y_q, org_z_q;
	logic [23:0] inv_x_q, inv_y_q, inv_z_q;
	logic [5:0]  plim_q;
	logic [14:0] vlim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0; org_y_q <= '0; org_z_q <= '0;
			inv_x_q <= 24'd65536; inv_y_q <= 24'd65536; inv_z_q <= 24'd65536;
			plim_q <= 6'd32; vlim_q <= 15'd16384;
		end else if (cfg_we) begin
			case (pcv_pkg::reg_idx_t'(cfg_idx))
				pcv_pkg::REG_ORIGIN_X: org_x_q <= cfg_data;
				pcv_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data;
				pcv_pkg::REG_ORIGIN_Z: org_z_q <= cfg_data;
				pcv_pkg::REG_INV_X:    inv_x_q <= cfg_data;
				pcv_pkg::REG_INV_Y:    inv_y_q <= cfg_data;
				pcv_pkg::REG_INV_Z:    inv_z_q <= cfg_data;
				pcv_pkg::REG_PLIM:     plim_q <= cfg_data[5:0];
				pcv_pkg::REG_VLIM:     vlim_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// stage 1: differences
	logic signed [24:0] dx_s1, dy_s1, dz_s1;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_s1 <= 25'(point.point_x) - 25'(org_x_q);
			dy_s1 <= 25'(point.point_y) - 25'(org_y_q);
			dz_s1 <= 25'(point.point_z) - 25'(org_z_q);
		end
	end

	// stage 2: products (25 x 25 signed each), range checks
	logic signed [49:0] px, py, pz;
	assign px = dx_s1 * $signed({1'b0, inv_x_q});
	assign py = dy_s1 * $signed({1'b0, inv_y_q});
	assign pz = dz_s1 * $signed({1'b0, inv_z_q});

	function automatic logic axis_in(input logic signed [49:0] p, input int grid);
		logic [25:0] c;
		c = p[49:24];
		return !p[49] && (c < 26'(grid));
	endfunction

	logic in_s2;
	logic [pcv_pkg::CX_W-1:0] cx_s2;
	logic [pcv_pkg::CY_W-1:0] cy_s2;
	logic [pcv_pkg::CZ_W-1:0] cz_s2;
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			in_s2 <= axis_in(px, pcv_pkg::GRID_X) && axis_in(py, pcv_pkg::GRID_Y)
				&& axis_in(pz, pcv_pkg::GRID_Z);
			cx_s2 <= px[24 +: pcv_pkg::CX_W];
			cy_s2 <= py[24 +: pcv_pkg::CY_W];
			cz_s2 <= pz[24 +: pcv_pkg::CZ_W];
		end
	end

	logic [pcv_pkg::CELL_W-1:0] addr;
	assign addr = {cz_s2, cy_s2, cx_s2};

	// memories
	logic [pcv_pkg::VOX_W-1:0]  map_mem [NCELL];
	logic                       used_mem [NCELL];
	logic [pcv_pkg::CELL_W-1:0] list_mem [pcv_pkg::VOXEL_CAPACITY];
	logic [pcv_pkg::FILL_W-1:0] fill_mem [pcv_pkg::VOXEL_CAPACITY];

	logic [pcv_pkg::VOX_W-1:0]  map_rd;
	logic                       used_rd;
	logic [pcv_pkg::CELL_W-1:0] list_rd;
	logic [pcv_pkg::FILL_W-1:0] fill_rd;

	logic [pcv_pkg::CNT_W-1:0]  count_q;
	logic [pcv_pkg::CNT_W-1:0]  walk_q;
	logic [pcv_pkg::CELL_W:0]   init_q;
	logic                       clr_wr_q;

	logic alloc, tfull;
	logic [pcv_pkg::FILL_W-1:0] fcur;

	// used bits: init sweep, allocate, clear walk (one write per cycle)
	logic                       used_we, used_wd;
	logic [pcv_pkg::CELL_W-1:0] used_wa;
	always_comb begin
		used_we = 1'b0; used_wd = 1'b0; used_wa = addr;
		if (cmd.init_step) begin
			used_we = 1'b1; used_wa = init_q[pcv_pkg::CELL_W-1:0];
		end else if (clr_wr_q) begin
			used_we = 1'b1; used_wa = list_rd;
		end else if (alloc) begin
			used_we = 1'b1; used_wd = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (used_we) used_mem[used_wa] <= used_wd;
		used_rd <= used_mem[addr];
		map_rd <= map_mem[addr];
		if (alloc) map_mem[addr] <= count_q[pcv_pkg::VOX_W-1:0];
	end

	// fill step: decide voxel
	logic [pcv_pkg::CNT_W-1:0] vlim_sat;
	logic [pcv_pkg::FILL_W-1:0] plim_sat;
	assign vlim_sat = (vlim_q > 15'(pcv_pkg::VOXEL_CAPACITY))
		? pcv_pkg::CNT_W'(pcv_pkg::VOXEL_CAPACITY) : pcv_pkg::CNT_W'(vlim_q);
	assign plim_sat = (plim_q > 6'(pcv_pkg::SLOT_CAPACITY))
		? pcv_pkg::FILL_W'(pcv_pkg::SLOT_CAPACITY) : pcv_pkg::FILL_W'(plim_q);

	assign alloc = cmd.fill && in_s2 && !used_rd && (count_q < vlim_sat);
	assign tfull = in_s2 && !used_rd && !(count_q < vlim_sat);

	logic [pcv_pkg::VOX_W-1:0] vidx_s3;
	logic in_s3, tfull_s3, newv_s3;
	logic [pcv_pkg::VOX_W-1:0] vsel;
	assign vsel = used_rd ? map_rd : count_q[pcv_pkg::VOX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			vidx_s3 <= vsel;
			in_s3 <= in_s2;
			tfull_s3 <= tfull;
			newv_s3 <= alloc;
		end
	end

	assign fcur = newv_s3 ? '0 : fill_rd;

	// fill memory and list memory
	logic [pcv_pkg::CNT_W-1:0] list_ra;
	assign list_ra = cmd.clr_start ? '0 : walk_q;
	always_ff @(posedge clk) begin
		fill_rd <= fill_mem[vsel];
		if (alloc) list_mem[count_q[pcv_pkg::VOX_W-1:0]] <= addr;
		list_rd <= list_mem[list_ra[pcv_pkg::VOX_W-1:0]];
		if (cmd.finish && in_s3 && !tfull_s3 && (fcur < plim_sat))
			fill_mem[vidx_s3] <= fcur + 1'b1;
	end

	logic vfull;
	assign vfull = !(fcur < plim_sat);

	logic [pcv_pkg::CNT_W-1:0] walk_end_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			walk_q <= '0;
			init_q <= '0;
			clr_wr_q <= 1'b0;
			walk_end_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.init_step) init_q <= init_q + 1'b1;
			if (alloc) count_q <= count_q + 1'b1;
			clr_wr_q <= 1'b0;
			if (cmd.clr_start) begin
				walk_q <= pcv_pkg::CNT_W'(1);
				walk_end_q <= count_q;
				clr_wr_q <= (count_q != '0);
				count_q <= '0;
			end else if (cmd.clr_step) begin
				clr_wr_q <= (walk_q < walk_end_q);
				walk_q <= walk_q + 1'b1;
			end
		end
	end

	assign sts.init_done = (init_q == (pcv_pkg::CELL_W + 1)'(NCELL - 1));
	assign sts.clr_done = cmd.clr_step && !(walk_q < walk_end_q);

	pcv_pkg::result_t res_d;
	always_comb begin
		res_d = '0;
		res_d.status = pcv_pkg::ST_OUT_GRID;
		if (in_s3) begin
			res_d.cell_x = 8'(cx_s2);
			res_d.cell_y = 8'(cy_s2);
			res_d.cell_z = 4'(cz_s2);
			res_d.new_voxel = newv_s3;
			if (tfull_s3) begin
				res_d.status = pcv_pkg::ST_TABLE_FULL;
			end else begin
				res_d.voxel_index = 14'(vidx_s3);
				res_d.status = vfull ? pcv_pkg::ST_VOXEL_FULL : pcv_pkg::ST_STORED;
				res_d.point_slot = vfull ? 5'd0 : 5'(fcur);
			end
		end
		res_d.voxel_count = 15'(count_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.finish)
			result <= res_d;
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pcv_pkg::CNT_W'(pcv_pkg::VOXEL_CAPACITY))
		else $error("voxel count beyond capacity");
	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> count_q == $past(count_q) + 1'b1)
		else $error("allocation did not bump count");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_start |=> count_q == '0)
		else $error("count not cleared at frame end");

endmodule

FILE: rtl/point_cloud_voxelizer.sv
// Top level of the point cloud voxelizer: controller plus datapath.
//  channel  | handshake          | payload
//  point    | start / busy       | point (point_t)
//  result   | done strobe        | result (result_t)
//  config   | cfg_we             | cfg_idx, cfg_data
// The done strobe follows the accepting edge and, for a point without frame_end,
// busy drops with it; between them lie the product stage, the cell map read, the
// fill memory read and the result register.
// A frame_end point adds a clear walk over the voxel list.
// After reset a clearing pass runs over the cell map; busy is high.
// Results cannot be stalled: done is high for exactly one cycle per point.
`timescale 1ns / 1ps
module point_cloud_voxelizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  pcv_pkg::point_t                point,
	output logic                           done,
	output pcv_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [pcv_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pcv_pkg::CFG_DATA_W-1:0] cfg_data
);

	pcv_pkg::dp_cmd_t cmd;
	pcv_pkg::dp_sts_t sts;

	pcv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .frame_end(point.frame_end),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	pcv_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .point(point), .cmd(cmd), .sts(sts),
		.done(done), .result(result)
	);

endmodule

FILE: test/point_cloud_voxelizer_tb.sv
// Testbench: random and directed points checked against a behavioural voxelizer.
`timescale 1ns / 1ps
module point_cloud_voxelizer_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pcv_pkg::point_t point = '0;
	logic done;
	pcv_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [pcv_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [pcv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	point_cloud_voxelizer u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// grid configuration as the block should hold it
	logic signed [23:0] org_x = 0, org_y = 0, org_z = 0;
	logic [23:0] inv_x = 24'd65536, inv_y = 24'd65536, inv_z = 24'd65536;
	logic [5:0] pts_limit = 6'd32;
	logic [14:0] vox_limit = 15'd16384;

	// voxel table state
	bit cell_taken[int];
	logic [13:0] cell_voxel[int];
	int voxel_cell[pcv_pkg::VOXEL_CAPACITY];
	int voxel_fill[pcv_pkg::VOXEL_CAPACITY];
	int voxels_used = 0;

	pcv_pkg::point_t pending_points[$];
	pcv_pkg::result_t expected_results[$];
	int errors = 0;
	int beats = 0;

	function automatic bit axis_cell(input logic signed [23:0] pos, input logic signed [23:0] org,
			input logic [23:0] inv, input int grid, output int cell_idx);
		longint d, p, q;
		d = longint'(pos) - longint'(org);
		p = d * longint'(inv);
		cell_idx = 0;
		if (p < 0)
			return 1'b0;
		q = p >>> 24;
		if (q >= grid)
			return 1'b0;
		cell_idx = int'(q);
		return 1'b1;
	endfunction

	task automatic voxelize(input pcv_pkg::point_t pt);
		pcv_pkg::result_t r;
		int cx, cy, cz, addr, vlim, plim, vidx, f;
		bit in_grid, have;
		r = '0;
		vlim = (vox_limit > pcv_pkg::VOXEL_CAPACITY) ? pcv_pkg::VOXEL_CAPACITY
			: int'(vox_limit);
		plim = (pts_limit > pcv_pkg::SLOT_CAPACITY) ? pcv_pkg::SLOT_CAPACITY
			: int'(pts_limit);
		in_grid = axis_cell(pt.point_x, org_x, inv_x, pcv_pkg::GRID_X, cx);
		if (in_grid)
			in_grid = axis_cell(pt.point_y, org_y, inv_y, pcv_pkg::GRID_Y, cy);
		if (in_grid)
			in_grid = axis_cell(pt.point_z, org_z, inv_z, pcv_pkg::GRID_Z, cz);
		if (!in_grid) begin
			r.status = pcv_pkg::ST_OUT_GRID;
		end else begin
			r.cell_x = 8'(cx);
			r.cell_y = 8'(cy);
			r.cell_z = 4'(cz);
			addr = (cz * pcv_pkg::GRID_Y + cy) * pcv_pkg::GRID_X + cx;
			have = 1'b1;
			vidx = 0;
			if (cell_taken.exists(addr)) begin
				vidx = int'(cell_voxel[addr]);
			end else if (voxels_used >= vlim) begin
				r.status = pcv_pkg::ST_TABLE_FULL;
				have = 1'b0;
			end else begin
				vidx = voxels_used;
				voxels_used++;
				cell_taken[addr] = 1'b1;
				cell_voxel[addr] = 14'(vidx);
				voxel_cell[vidx] = addr;
				voxel_fill[vidx] = 0;
				r.new_voxel = 1'b1;
			end
			if (have) begin
				r.voxel_index = 14'(vidx);
				f = voxel_fill[vidx % pcv_pkg::VOXEL_CAPACITY];
				if (f < plim) begin
					r.point_slot = 5'(f);
					voxel_fill[vidx % pcv_pkg::VOXEL_CAPACITY] = f + 1;
					r.status = pcv_pkg::ST_STORED;
				end else begin
					r.status = pcv_pkg::ST_VOXEL_FULL;
				end
			end
		end
		r.voxel_count = 15'(voxels_used);
		expected_results.push_back(r);
		if (pt.frame_end) begin
			for (int i = 0; i < voxels_used && i < pcv_pkg::VOXEL_CAPACITY; i++)
				cell_taken.delete(voxel_cell[i]);
			voxels_used = 0;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && busy) begin
			start <= 1'b1;
		end else begin
			bit idle;
			if (start) begin
				voxelize(point);
				beats++;
			end
			idle = (beats < 300 || beats > 500) && ($urandom_range(99) < 25);
			if (pending_points.size() != 0 && !idle) begin
				point <= pending_points.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", result);
			end else begin
				pcv_pkg::result_t exp_r;
				exp_r = expected_results.pop_front();
				if (result.status !== exp_r.status || result.voxel_index !== exp_r.voxel_index ||
						result.point_slot !== exp_r.point_slot || result.cell_x !== exp_r.cell_x ||
						result.cell_y !== exp_r.cell_y || result.cell_z !== exp_r.cell_z ||
						result.new_voxel !== exp_r.new_voxel ||
						result.voxel_count !== exp_r.voxel_count) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p actual %p", exp_r, result);
				end
			end
		end
	end

	task automatic write_reg(input pcv_pkg::reg_idx_t idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value[23:0];
		case (idx)
			pcv_pkg::REG_ORIGIN_X: org_x = value[23:0];
			pcv_pkg::REG_ORIGIN_Y: org_y = value[23:0];
			pcv_pkg::REG_ORIGIN_Z: org_z = value[23:0];
			pcv_pkg::REG_INV_X:    inv_x = value[23:0];
			pcv_pkg::REG_INV_Y:    inv_y = value[23:0];
			pcv_pkg::REG_INV_Z:    inv_z = value[23:0];
			pcv_pkg::REG_PLIM:     pts_limit = value[5:0];
			pcv_pkg::REG_VLIM:     vox_limit = value[14:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_points.size() != 0 || expected_results.size() != 0 || start || busy)
			@(posedge clk);
		repeat (16) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic push_point(input int x, input int y, input int z, input bit fe);
		pcv_pkg::point_t p;
		p.point_x = x[23:0];
		p.point_y = y[23:0];
		p.point_z = z[23:0];
		p.frame_end = fe;
		pending_points.push_back(p);
	endtask

	function automatic int span_of(input logic [23:0] inv, input int grid);
		longint s;
		if (inv == 0)
			return 1 << 23;
		s = (longint'(grid) << 24) / longint'(inv);
		if (s > (1 << 23))
			s = 1 << 23;
		if (s < 1)
			s = 1;
		return int'(s);
	endfunction

	task automatic random_phase(input int n, input int fe_pct);
		int pool[12][3];
		int sx, sy, sz, roll;
		sx = span_of(inv_x, pcv_pkg::GRID_X);
		sy = span_of(inv_y, pcv_pkg::GRID_Y);
		sz = span_of(inv_z, pcv_pkg::GRID_Z);
		foreach (pool[i]) begin
			pool[i][0] = $urandom_range(sx - 1);
			pool[i][1] = $urandom_range(sy - 1);
			pool[i][2] = $urandom_range(sz - 1);
		end
		for (int i = 0; i < n; i++) begin
			bit fe;
			int k;
			fe = ($urandom_range(99) < fe_pct);
			roll = $urandom_range(99);
			k = $urandom_range(11);
			if (roll < 65)
				push_point(org_x + pool[k][0], org_y + pool[k][1], org_z + pool[k][2], fe);
			else if (roll < 85)
				push_point(org_x + $urandom_range(sx - 1), org_y + $urandom_range(sy - 1),
					org_z + $urandom_range(sz - 1), fe);
			else
				push_point($urandom, $urandom, $urandom, 1'($urandom_range(1)));
		end
		push_point(org_x, org_y, org_z, 1'b1);
	endtask

	initial begin
		int ox, oy, oz, ix, iy, iz, pl, vl;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		// directed, reset grid: cell = coordinate / 256
		push_point(0, 0, 0, 0);
		push_point(255, 255, 255, 0);
		push_point(65535, 65535, 4095, 0);
		push_point(65536, 0, 0, 0);
		push_point(0, 65536, 0, 0);
		push_point(0, 0, 4096, 0);
		push_point(-1, 0, 0, 0);
		push_point(0, -1, 0, 0);
		push_point(0, 0, -1, 0);
		push_point(8388607, 8388607, 8388607, 0);
		push_point(-8388608, -8388608, -8388608, 0);
		push_point(256, 512, 768, 0);
		push_point(300, 600, 800, 1);
		push_point(0, 0, 0, 0);
		push_point(65535, 0, 4095, 0);
		push_point(-8388608, 8388607, 0, 1);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			ox = $urandom_range(20000) - 10000;
			oy = $urandom_range(20000) - 10000;
			oz = $urandom_range(20000) - 10000;
			ix = $urandom_range(16777215);
			iy = $urandom_range(262144);
			iz = $urandom_range(1048576);
			pl = $urandom_range(63);
			vl = $urandom_range(32767);
			case (ph)
				0: begin ox = 0; oy = 0; oz = 0; ix = 65536; iy = 65536; iz = 65536;
					pl = 1; vl = 5; end
				1: begin ox = -8388608; oy = -8388608; oz = -8388608;
					ix = 16777215; iy = 16777215; iz = 16777215; pl = 63; vl = 32767; end
				2: begin ox = 8388607; oy = 8388607; oz = 8388607; ix = 0; iy = 0; iz = 0;
					pl = 0; vl = 16384; end
				3: begin ox = -5000; oy = 1234; oz = -77; ix = 131072; iy = 32768; iz = 65536;
					pl = 32; vl = 0; end
				4: begin pl = 3; vl = 1; end
				5: begin pl = 2; vl = 20; end
				6: begin ox = 0; oy = 0; oz = 0; ix = 65536; iy = 65536; iz = 65536;
					pl = 32; vl = 16384; end
				default: ;
			endcase
			write_reg(pcv_pkg::REG_ORIGIN_X, ox);
			write_reg(pcv_pkg::REG_ORIGIN_Y, oy);
			write_reg(pcv_pkg::REG_ORIGIN_Z, oz);
			write_reg(pcv_pkg::REG_INV_X, ix);
			write_reg(pcv_pkg::REG_INV_Y, iy);
			write_reg(pcv_pkg::REG_INV_Z, iz);
			write_reg(pcv_pkg::REG_PLIM, pl);
			write_reg(pcv_pkg::REG_VLIM, vl);
			random_phase(160, (ph == 6) ? 10 : 3);
			wait_idle();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("point_cloud_voxelizer test passed");
		else
			$display("point_cloud_voxelizer test failed");
		$finish;
	end

	initial begin
		#200ms;
		$display("point_cloud_voxelizer test failed");
		$finish;
	end
endmodule

FILE: sim.f
rtl/pcv_pkg.sv
rtl/pcv_ctrl.sv
rtl/pcv_datapath.sv
rtl/point_cloud_voxelizer.sv
test/point_cloud_voxelizer_tb.sv
